FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clock, muted while reset is high.

// Antecedent holds now, consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent holds now, consequent must hold in the same cycle.
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: design/ile_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int POS_BITS   = 5;
   localparam int ELEM_BITS  = 32;
   localparam int COUNT_BITS = 5;

   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_READ   = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [POS_BITS-1:0]   position;
      logic [ELEM_BITS-1:0]  element;
   } req_item_type;

   typedef struct packed {
      logic [ELEM_BITS-1:0]  word_out;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the request
      logic exec;   // apply it to the row and latch the result
   } ctl_cmd_type;

endpackage

`default_nettype wire

FILE: design/indexed_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          transfer when
// -------   -----------------------------  ---------------------------------
// request   start, busy, req_item          start high and busy low at edge
// response  rsp_strobe, rsp_item           rsp_strobe high (one cycle only)
//
// A command is captured while idle, then applied in the exec state to the
// register row, where insert and remove shift all slots in parallel.
// rsp_strobe rises the cycle after execution, the same cycle busy drops,
// so a new command may be taken while the result is shown.
// reset (synchronous) empties the list and idles the controller; slot
// contents are not cleared, so no clearing pass is needed.
// The receiver cannot stall; each result is shown for one cycle only.

module indexed_list_engine_core
   import ile_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   // load/exec from the controller drive the datapath
   ctl_cmd_type ctl;

   ile_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .ctl        (ctl),
      .rsp_strobe (rsp_strobe)
   );

   // holds the list (slot row plus fill count) and the result register
   ile_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

FILE: design/ile_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ile_datapath
   import ile_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  ctl_cmd_type  ctl,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);

   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS  = (FILL_BITS > POS_BITS) ? FILL_BITS : POS_BITS;

   req_item_type         req_ff;
   rsp_item_type         rsp_ff;
   logic [FILL_BITS-1:0] fill_ff;
   logic [WORD_BITS-1:0] slot_ff [DEPTH];

   logic [CMP_BITS-1:0]  pos_x;
   logic [CMP_BITS-1:0]  fill_x;
   logic [CMP_BITS-1:0]  ins_pos;
   logic [IDX_BITS-1:0]  rd_idx;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] elem_w;
   logic [FILL_BITS-1:0] fill_in;
   logic [FILL_BITS-1:0] fill_dec;
   logic                 full;
   logic                 empty;
   logic                 do_ins;
   logic                 do_rem;
   logic                 do_rd;
   status_type           status;

   assign pos_x    = CMP_BITS'(req_ff.position);
   assign fill_x   = CMP_BITS'(fill_ff);
   assign fill_dec = fill_ff - FILL_BITS'(1);
   assign full     = (fill_ff == FILL_BITS'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign elem_w   = WORD_BITS'(req_ff.element);
   assign rd_word  = slot_ff[rd_idx];

   always_comb begin
      do_ins  = 1'b0;
      do_rem  = 1'b0;
      do_rd   = 1'b0;
      ins_pos = pos_x;
      rd_idx  = IDX_BITS'(pos_x);
      fill_in = fill_ff;
      status  = ST_OK;
      case (req_ff.cmd)
         CMD_PUSH: begin
            ins_pos = fill_x;
            if (full) begin
               status = ST_FULL;
            end else begin
               do_ins  = 1'b1;
               fill_in = fill_ff + FILL_BITS'(1);
            end
         end
         CMD_POP: begin
            rd_idx = IDX_BITS'(fill_dec);
            if (empty) begin
               status = ST_INVALID;
            end else begin
               do_rd   = 1'b1;
               fill_in = fill_dec;
            end
         end
         CMD_READ: begin
            if (pos_x >= fill_x) begin
               status = ST_INVALID;
            end else begin
               do_rd = 1'b1;
            end
         end
         CMD_INSERT: begin
            if (pos_x > fill_x) begin
               status = ST_INVALID;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               do_ins  = 1'b1;
               fill_in = fill_ff + FILL_BITS'(1);
            end
         end
         CMD_REMOVE: begin
            if (pos_x >= fill_x) begin
               status = ST_INVALID;
            end else begin
               do_rd   = 1'b1;
               do_rem  = 1'b1;
               fill_in = fill_dec;
            end
         end
         CMD_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

   // register row: every slot picks hold, new word, lower or upper neighbor
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_slot
      // end slots point the missing neighbor at themselves; that select never fires
      localparam int LO_IDX = (gi == 0) ? 0 : gi - 1;
      localparam int HI_IDX = (gi == DEPTH - 1) ? gi : gi + 1;

      logic take_elem;
      logic take_lo;
      logic take_hi;

      assign take_elem = do_ins && (CMP_BITS'(gi) == ins_pos);
      assign take_lo   = do_ins && (CMP_BITS'(gi) > ins_pos) && (CMP_BITS'(gi) <= fill_x);
      assign take_hi   = do_rem && (CMP_BITS'(gi) >= pos_x)
                         && (CMP_BITS'(gi + 1) < fill_x);

      always_ff @(posedge clock) begin
         if (ctl.exec) begin
            if (take_elem) begin
               slot_ff[gi] <= elem_w;
            end else if (take_lo) begin
               slot_ff[gi] <= slot_ff[LO_IDX];
            end else if (take_hi) begin
               slot_ff[gi] <= slot_ff[HI_IDX];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (ctl.exec) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_item;
      end
      if (ctl.exec) begin
         rsp_ff.word_out <= do_rd ? ELEM_BITS'(rd_word) : '0;
         rsp_ff.status   <= status;
         rsp_ff.count    <= COUNT_BITS'(fill_in);
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

FILE: design/ile_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ile_ctrl
   import ile_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   output ctl_cmd_type ctl,
   output logic        rsp_strobe
);

   fsm_type state_ff;
   fsm_type state_in;
   logic    strobe_ff;
   logic    strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy      = 1'b0;
      ctl.load  = 1'b0;
      ctl.exec  = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            busy     = 1'b1;
            ctl.exec = 1'b1;
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
      strobe_in = ctl.exec;
   end

   assign rsp_strobe = strobe_ff;

   `ASSERT_NEXT(a_accept_execs, start && !busy, ctl.exec, "accepted command not executed")
   `ASSERT_NEXT(a_exec_strobes, ctl.exec, rsp_strobe, "executed command gave no result")
   `ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "result strobe repeated")
   `ASSERT_NOW(a_no_load_busy, ctl.load, !busy && !ctl.exec, "load while busy")

endmodule

`default_nettype wire

FILE: test/tb_indexed_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_indexed_list_engine_core
   import ile_pkg::*;
();

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   // cycles to idle after the last result
   localparam int SETTLE_TICKS = 8;
   // encodings outside cmd_type; the block answers them as invalid
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   // shadow copy of the list, updated at each accepted command
   logic [ELEM_BITS-1:0] list_words [LIST_DEPTH];
   int unsigned          list_fill = 0;

   // results still owed by the block, oldest first
   rsp_item_type pending_rsp [$];

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   // cleared for back-to-back stretches
   bit          gaps_on     = 1'b1;

   indexed_list_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one command to the shadow list and work out the result it owes.
   task automatic apply_command(input req_item_type c, output rsp_item_type r);
      int pos;
      r        = '0;
      r.status = ST_OK;
      pos      = int'(c.position);
      case (c.cmd)
         CMD_PUSH: begin
            if (list_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_words[list_fill] = c.element;
               list_fill++;
            end
         end
         CMD_POP: begin
            if (list_fill == 0) begin
               r.status = ST_INVALID;
            end else begin
               list_fill--;
               r.word_out = list_words[list_fill];
            end
         end
         CMD_READ: begin
            if (pos >= int'(list_fill)) r.status = ST_INVALID;
            else r.word_out = list_words[pos];
         end
         CMD_INSERT: begin
            // position check wins over the full check
            if (pos > int'(list_fill)) begin
               r.status = ST_INVALID;
            end else if (list_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = int'(list_fill); i > pos; i--)
                  list_words[i] = list_words[i-1];
               list_words[pos] = c.element;
               list_fill++;
            end
         end
         CMD_REMOVE: begin
            if (pos >= int'(list_fill)) begin
               r.status = ST_INVALID;
            end else begin
               r.word_out = list_words[pos];
               for (int i = pos; i + 1 < int'(list_fill); i++)
                  list_words[i] = list_words[i+1];
               list_fill--;
            end
         end
         CMD_CLEAR: list_fill = 0;
         default:   r.status = ST_INVALID;
      endcase
      r.count = list_fill[COUNT_BITS-1:0];
   endtask

   // Drive one command, hold it until the transfer, log the result it owes,
   // then maybe idle. start stays high when the next command follows at once.
   task automatic issue_command(input cmd_type op, input int unsigned pos,
                                input logic [ELEM_BITS-1:0] word);
      req_item_type item;
      rsp_item_type outcome;
      int unsigned  roll;
      int unsigned  gap;
      logic [63:0]  junk;
      item.cmd      = op;
      item.position = pos[POS_BITS-1:0];
      item.element  = word;
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      apply_command(item, outcome);
      pending_rsp.push_back(outcome);

      // mostly short gaps, a few long ones
      roll = $urandom_range(99);
      if (!gaps_on || roll < 55) gap = 0;
      else if (roll < 88) gap = $urandom_range(3, 1);
      else if (roll < 97) gap = $urandom_range(10, 4);
      else gap = $urandom_range(40, 16);
      if (gap != 0) begin
         start <= 1'b0;
         // junk on the payload while start is low must be ignored
         junk = {$urandom, $urandom};
         req_item <= junk[$bits(req_item_type)-1:0];
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every owed result has arrived.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Every failure path on an empty list, plus an unknown opcode.
   task automatic test_empty_list();
      issue_command(CMD_POP, 0, $urandom);
      issue_command(CMD_READ, 0, $urandom);
      issue_command(CMD_REMOVE, 31, $urandom);
      issue_command(CMD_INSERT, 1, $urandom);
      issue_command(cmd_type'(CMD_UNUSED_6), $urandom_range(31), $urandom);
   endtask

   // Fill to capacity with a mix of push and insert, then push against the
   // limit: insert at fill when full reports full, one past fill is invalid.
   task automatic test_fill_to_capacity();
      issue_command(CMD_PUSH, 31, 32'h0000_0000);
      issue_command(CMD_PUSH, 0, 32'hFFFF_FFFF);
      issue_command(CMD_INSERT, 0, 32'hA5A5_A5A5);
      // insert at the end behaves as push
      issue_command(CMD_INSERT, 3, 32'h5A5A_5A5A);
      issue_command(CMD_INSERT, 2, $urandom);
      while (list_fill < LIST_DEPTH) begin
         if ($urandom_range(1)) issue_command(CMD_PUSH, $urandom_range(31), $urandom);
         else issue_command(CMD_INSERT, $urandom_range(list_fill), $urandom);
      end
      issue_command(CMD_PUSH, 0, $urandom);
      issue_command(CMD_INSERT, LIST_DEPTH, $urandom);
      issue_command(CMD_INSERT, LIST_DEPTH + 1, $urandom);
   endtask

   // Last slot, one past it, then front removal, pop and clear, from a full list.
   task automatic test_boundary_access();
      issue_command(CMD_READ, LIST_DEPTH - 1, $urandom);
      issue_command(CMD_READ, LIST_DEPTH, $urandom);
      issue_command(CMD_REMOVE, 0, $urandom);
      issue_command(CMD_POP, 0, $urandom);
      issue_command(CMD_CLEAR, $urandom_range(31), $urandom);
   endtask

   // Bursts that lean toward growing, shrinking or churning the list, so the
   // fill level sweeps between empty and full many times.
   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned          sent;
      int unsigned          burst_left;
      int unsigned          grow_pct;
      int unsigned          roll;
      int unsigned          pos;
      cmd_type              op;
      logic [ELEM_BITS-1:0] word;
      sent       = 0;
      burst_left = 0;
      grow_pct   = 50;
      while (sent < n_items) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(60, 20);
            case ($urandom_range(2))
               0:       grow_pct = 75;
               1:       grow_pct = 25;
               default: grow_pct = 50;
            endcase
            gaps_on = ($urandom_range(3) != 0);
         end

         roll = $urandom_range(99);
         if (roll < 2) op = CMD_CLEAR;
         else if (roll < 4) op = cmd_type'(roll[0] ? CMD_UNUSED_7 : CMD_UNUSED_6);
         else if (roll < 20) op = CMD_READ;
         else if ($urandom_range(99) < grow_pct)
            op = $urandom_range(1) ? CMD_PUSH : CMD_INSERT;
         else
            op = $urandom_range(1) ? CMD_POP : CMD_REMOVE;

         // mostly in range; the rest anywhere the field reaches
         if ($urandom_range(99) < 85) pos = $urandom_range(list_fill);
         else pos = $urandom_range(31);

         roll = $urandom_range(9);
         if (roll == 0) word = '0;
         else if (roll == 1) word = '1;
         else word = $urandom;

         issue_command(op, pos, word);
         sent++;
         burst_left--;
      end
   endtask

   // Let the block go fully idle, then read back every held entry.
   task automatic test_drained_readback();
      wait_for_drain();
      gaps_on = 1'b1;
      for (int i = 0; i < int'(list_fill); i++)
         issue_command(CMD_READ, i, $urandom);
   endtask

   // Compare each result transfer with the oldest owed result.
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: word_out %h status %0d count %0d",
                   rsp_item.word_out, rsp_item.status, rsp_item.count);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.word_out !== want.word_out) begin
               $error("word_out: expected %h, got %h", want.word_out, rsp_item.word_out);
               fail_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_item.count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part runs back to back
      gaps_on = 1'b0;
      test_empty_list();
      test_fill_to_capacity();
      test_boundary_access();

      test_random_traffic(640);
      test_drained_readback();
      test_random_traffic(640);

      wait_for_drain();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
